// File: hw/rtl/ktb_pkg.sv
// Shared types and constants for the keyword trie builder.
package ktb_pkg;

  localparam int CHAR_W   = 8;
  localparam int LINK_W   = 8;
  localparam int ID_W     = 8;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT     = 2'd0,
    REQ_CLEAR_KEEP = 2'd1,
    REQ_CLEAR_ALL  = 2'd2,
    REQ_UNUSED     = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_RSVD      = 2'd3
  } status_t;

endpackage

// File: hw/rtl/keyword_trie_builder_unit.sv
// Keyword trie builder: one transition memory walked by a read-modify-write sequencer.
//
//  channel | direction | tdata                            | tuser     | tlast
//  s_*     | in        | char_code                        | req_type  | last_char
//  m_*     | out       | row_reached, row_created, token  | status    | -
//
// An insert goes through accept and memory read, decide and output load, plus an exit step
// when a token id is written: the exit entry is read while deciding and written in that step.
// A skipped character or an unused request code goes straight from accept to output load.
// The word is offered on m_* from the cycle after the output load.
// A clear walks every entry of the rows in use, one entry per cycle, then loads its reply.
// After reset all ROWS rows (ROWS * 2**ceil(log2(ALPHABET)) entries) are swept the same
// way with s_tready low. A stalled output holds the finished word; the next word may be
// accepted and worked on meanwhile, but waits in the output load until the word is taken.
module keyword_trie_builder_unit #(
  parameter int ROWS       = 256,
  parameter int ALPHABET   = 256,
  parameter int MAX_TOKENS = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_code[7:0]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  input  logic        s_tlast,   // last_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // row_reached[7:0], row_created[8], token_id[16:9], zeros
  output logic [1:0]  m_tuser    // status[1:0]
);

  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AW    = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int MA    = RW + AW;
  localparam int DEPTH = 2 ** MA;
  localparam int WW    = ktb_pkg::ID_W + ktb_pkg::LINK_W;
  localparam int NCH   = 2 ** ktb_pkg::CHAR_W;

  typedef logic [NCH-1:0][AW-1:0] fold_t;

  function automatic fold_t make_fold();
    fold_t f;
    for (int i = 0; i < NCH; i++) begin
      f[i] = AW'(i % ALPHABET);
    end
    return f;
  endfunction

  localparam fold_t FOLD = make_fold();

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOOK  = 5'b00010,
    S_EXIT  = 5'b00100,
    S_CLEAR = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state;

  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] rd_data;
  logic          rd_en;
  logic [MA-1:0] rd_addr;
  logic          wr_en;
  logic [MA-1:0] wr_addr;
  logic [WW-1:0] wr_data;

  logic [RW:0]         next_free_row;
  logic [RW-1:0]       walk_row;
  logic [ktb_pkg::ID_W-1:0] id_count;
  logic                skipping;
  logic [AW-1:0]       ch;
  logic                last;
  logic [MA-1:0]       clr_addr;
  logic [RW-1:0]       clr_last;
  logic                clr_reply;

  logic [RW-1:0]            res_row;
  logic                     res_created;
  logic [ktb_pkg::ID_W-1:0] res_id;
  ktb_pkg::status_t         res_status;

  logic [7:0]               out_row;
  logic                     out_created;
  logic [ktb_pkg::ID_W-1:0] out_id;
  ktb_pkg::status_t         out_status;

  logic [ktb_pkg::LINK_W-1:0] link;
  logic                       miss;
  logic                       full;
  logic                       ok;
  logic [RW-1:0]              nxt_row;
  logic                       exit_go;
  logic                       s_fire;
  logic                       out_free;

  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign link    = rd_data[ktb_pkg::LINK_W-1:0];
  assign miss    = (link == '0);
  assign full    = (next_free_row >= (RW+1)'(ROWS));
  assign ok      = !miss || !full;
  assign nxt_row = miss ? next_free_row[RW-1:0] : link[RW-1:0];
  assign exit_go = ok && last && (id_count < ktb_pkg::ID_W'(MAX_TOKENS));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {walk_row, FOLD[s_tdata]};
    wr_en   = 1'b0;
    wr_addr = {walk_row, ch};
    wr_data = '0;
    unique case (state)
      S_IDLE: begin
        rd_en = s_fire && (ktb_pkg::req_t'(s_tuser) == ktb_pkg::REQ_INSERT) && !skipping;
      end
      S_LOOK: begin
        wr_en   = miss && !full;
        wr_data = {rd_data[WW-1:ktb_pkg::LINK_W], ktb_pkg::LINK_W'(next_free_row)};
        rd_en   = exit_go;
        rd_addr = {nxt_row, ch};
      end
      S_EXIT: begin
        wr_en   = 1'b1;
        wr_addr = {res_row, ch};
        wr_data = {res_id, link};
      end
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      clr_last      <= RW'(ROWS - 1);
      clr_reply     <= 1'b0;
      next_free_row <= (RW+1)'(1);
      walk_row      <= '0;
      id_count      <= '0;
      skipping      <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            ch          <= FOLD[s_tdata];
            last        <= s_tlast;
            res_row     <= '0;
            res_created <= 1'b0;
            res_id      <= '0;
            res_status  <= ((ktb_pkg::req_t'(s_tuser) == ktb_pkg::REQ_INSERT) && skipping)
                           ? ktb_pkg::ST_FULL : ktb_pkg::ST_OK;
            case (ktb_pkg::req_t'(s_tuser)) inside
              ktb_pkg::REQ_INSERT: begin
                if (skipping) begin
                  if (s_tlast) begin
                    walk_row <= '0;
                    skipping <= 1'b0;
                  end
                  state <= S_OUT;
                end else begin
                  state <= S_LOOK;
                end
              end
              ktb_pkg::REQ_CLEAR_KEEP, ktb_pkg::REQ_CLEAR_ALL: begin
                clr_last      <= RW'(next_free_row - (RW+1)'(1));
                clr_addr      <= '0;
                clr_reply     <= 1'b1;
                next_free_row <= (RW+1)'(1);
                walk_row      <= '0;
                skipping      <= 1'b0;
                if (ktb_pkg::req_t'(s_tuser) == ktb_pkg::REQ_CLEAR_ALL) begin
                  id_count <= '0;
                end
                state <= S_CLEAR;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_LOOK: begin
          if (!ok) begin
            res_status <= ktb_pkg::ST_FULL;
            skipping   <= !last;
            if (last) begin
              walk_row <= '0;
            end
            state <= S_OUT;
          end else begin
            res_row     <= nxt_row;
            res_created <= miss;
            if (miss) begin
              next_free_row <= next_free_row + (RW+1)'(1);
            end
            walk_row <= last ? '0 : nxt_row;
            if (exit_go) begin
              id_count <= id_count + ktb_pkg::ID_W'(1);
              res_id   <= id_count + ktb_pkg::ID_W'(1);
              state    <= S_EXIT;
            end else begin
              if (last) begin
                res_status <= ktb_pkg::ST_EXHAUSTED;
              end
              state <= S_OUT;
            end
          end
        end
        S_EXIT: begin
          state <= S_OUT;
        end
        S_CLEAR: begin
          if (clr_addr == {clr_last, {AW{1'b1}}}) begin
            state <= clr_reply ? S_OUT : S_IDLE;
          end else begin
            clr_addr <= clr_addr + MA'(1);
          end
        end
        S_OUT: begin
          if (out_free) begin
            m_tvalid    <= 1'b1;
            out_row     <= 8'(res_row);
            out_created <= res_created;
            out_id      <= res_id;
            out_status  <= res_status;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {7'd0, out_id, out_created, out_row};
  assign m_tuser = out_status;

endmodule

// File: bench/tb_keyword_trie_builder_unit.sv
// Self-checking testbench for the keyword trie builder with a scoreboard class.
module tb_keyword_trie_builder_unit;

  localparam int ROWS        = 256;
  localparam int ALPHABET    = 256;
  localparam int MAX_TOKENS  = 255;
  localparam int QUIET_LIMIT = 300000;
  localparam int TOTAL_WORDS = 950;

  typedef struct packed {
    logic [ktb_pkg::LINK_W-1:0] row;
    logic                       created;
    logic [ktb_pkg::ID_W-1:0]   id;
    ktb_pkg::status_t           status;
  } walk_result_t;

  class trie_scoreboard;
    logic [ktb_pkg::LINK_W-1:0] link_table [ROWS*ALPHABET];
    int                next_free_row;
    int                cur_row;
    int                id_count;
    bit                skipping;
    walk_result_t      pending_results [$];
    int                errors;

    function new();
      clear_rows();
      id_count = 0;
      errors = 0;
    endfunction

    function void clear_rows();
      foreach (link_table[i]) link_table[i] = '0;
      next_free_row = 1;
      cur_row = 0;
      skipping = 1'b0;
    endfunction

    function void note_request(ktb_pkg::req_t req, logic [ktb_pkg::CHAR_W-1:0] ch,
                               logic last);
      walk_result_t r;
      int idx;
      int nxt;
      r = '0;
      case (req) inside
        ktb_pkg::REQ_CLEAR_KEEP, ktb_pkg::REQ_CLEAR_ALL: begin
          clear_rows();
          if (req == ktb_pkg::REQ_CLEAR_ALL) id_count = 0;
        end
        ktb_pkg::REQ_INSERT: begin
          if (skipping) begin
            r.status = ktb_pkg::ST_FULL;
          end else begin
            idx = cur_row * ALPHABET + (ch % ALPHABET);
            nxt = link_table[idx];
            if (nxt == 0 && next_free_row >= ROWS) begin
              r.status = ktb_pkg::ST_FULL;
              skipping = 1'b1;
            end else begin
              if (nxt == 0) begin
                nxt = next_free_row;
                link_table[idx] = ktb_pkg::LINK_W'(nxt);
                next_free_row++;
                r.created = 1'b1;
              end
              cur_row = nxt % ROWS;
              r.row = ktb_pkg::LINK_W'(cur_row);
              if (last) begin
                if (id_count >= MAX_TOKENS) begin
                  r.status = ktb_pkg::ST_EXHAUSTED;
                end else begin
                  id_count++;
                  r.id = ktb_pkg::ID_W'(id_count);
                end
              end
            end
          end
          if (last) begin
            cur_row = 0;
            skipping = 1'b0;
          end
        end
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    function void report(string field, int exp_val, int act_val);
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_val, act_val);
    endfunction

    function void check_response(logic [23:0] data, logic [1:0] user);
      walk_result_t r;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none actual data %h user %h",
                 $time, data, user);
        return;
      end
      r = pending_results.pop_front();
      if (data[7:0] !== r.row) report("row_reached", r.row, data[7:0]);
      if (data[8] !== r.created) report("row_created", r.created, data[8]);
      if (data[16:9] !== r.id) report("token_id", r.id, data[16:9]);
      if (user !== r.status) report("status", r.status, user);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [1:0]  s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;

  trie_scoreboard sb = new();
  int             word_count;
  int             tx_idle_pct;
  int             rx_idle_pct;
  bit             rx_hold_req;
  int             quiet_cycles;
  logic [7:0]     narrow_chars [4];

  keyword_trie_builder_unit #(
    .ROWS       (ROWS),
    .ALPHABET   (ALPHABET),
    .MAX_TOKENS (MAX_TOKENS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_keyword_trie_builder_unit: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : receiver
    int stall_left;
    int hold_left;
    bit hold_done;
    stall_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_response(m_tdata, m_tuser);
      if (rx_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
        stall_left = $urandom_range(1, 9) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(input ktb_pkg::req_t req, input logic [7:0] ch, input logic last);
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= ch;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(req, ch, last);
    word_count++;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_keyword(input bit wide);
    int         len;
    logic [7:0] ch;
    len = $urandom_range(1, 4);
    for (int i = 0; i < len; i++) begin
      if (wide || $urandom_range(0, 9) == 0) ch = 8'($urandom_range(0, 255));
      else ch = narrow_chars[$urandom_range(0, 3)];
      if ($urandom_range(0, 99) < 3)
        send_word(ktb_pkg::REQ_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      if (sb.next_free_row < 24 && $urandom_range(0, 99) == 0)
        send_word(ktb_pkg::REQ_CLEAR_KEEP, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      send_word(ktb_pkg::REQ_INSERT, ch, i == len - 1);
    end
  endtask

  task automatic run_phase(input bit wide, input int stop_count, input int idle_pct);
    foreach (narrow_chars[k]) narrow_chars[k] = 8'($urandom_range(0, 255));
    tx_idle_pct = idle_pct;
    rx_idle_pct = idle_pct;
    if (wide) begin
      while (sb.next_free_row < ROWS && word_count < stop_count) send_keyword(1'b1);
      repeat (15) send_keyword(1'b1);
    end else begin
      while (word_count < stop_count) send_keyword(1'b0);
    end
    drain_results();
    if (sb.id_count >= MAX_TOKENS)
      send_word(ktb_pkg::REQ_CLEAR_ALL, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    else
      send_word(ktb_pkg::REQ_CLEAR_KEEP, 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst          <= 1'b1;
    s_tvalid     <= 1'b0;
    s_tdata      <= '0;
    s_tuser      <= ktb_pkg::REQ_INSERT;
    s_tlast      <= 1'b0;
    word_count   = 0;
    tx_idle_pct  = 20;
    rx_idle_pct  = 20;
    rx_hold_req  = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(ktb_pkg::REQ_INSERT, 8'h00, 1'b0);
    send_word(ktb_pkg::REQ_INSERT, 8'hFF, 1'b1);
    send_word(ktb_pkg::REQ_INSERT, 8'h00, 1'b0);
    send_word(ktb_pkg::REQ_INSERT, 8'hFF, 1'b1);
    send_word(ktb_pkg::REQ_INSERT, 8'h61, 1'b1);
    send_word(ktb_pkg::REQ_INSERT, 8'h55, 1'b0);
    send_word(ktb_pkg::REQ_UNUSED, 8'hAA, 1'b1);
    send_word(ktb_pkg::REQ_INSERT, 8'hAA, 1'b1);
    send_word(ktb_pkg::REQ_UNUSED, 8'h00, 1'b0);
    send_word(ktb_pkg::REQ_CLEAR_KEEP, 8'hFF, 1'b1);
    send_word(ktb_pkg::REQ_INSERT, 8'hFF, 1'b1);
    send_word(ktb_pkg::REQ_INSERT, 8'h80, 1'b0);
    send_word(ktb_pkg::REQ_CLEAR_ALL, 8'h01, 1'b0);
    send_word(ktb_pkg::REQ_INSERT, 8'h80, 1'b1);
    send_word(ktb_pkg::REQ_INSERT, 8'h7F, 1'b1);
    drain_results();

    run_phase(1'b1, 500, 15);
    rx_hold_req = 1'b1;
    run_phase(1'b0, word_count + 220, 0);
    run_phase(1'b1, 880, 30);
    run_phase(1'b0, TOTAL_WORDS, 0);

    drain_results();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("tb_keyword_trie_builder_unit: PASS");
    end else begin
      $display("tb_keyword_trie_builder_unit: FAIL");
    end
    $finish;
  end

endmodule
